@@ design/tfpt_pkg.sv @@
// Shared types and constants for the FIFO-replaced TLB translation block.
// Used by tfpt_tlb, tfpt_mem, the top level and the testbench; no dependencies.
package tfpt_pkg;

    localparam int DEF_OFFSET_BITS       = 8;
    localparam int DEF_PAGE_NUMBER_BITS  = 8;
    localparam int DEF_FRAME_NUMBER_BITS = 8;
    localparam int DEF_TLB_ENTRIES       = 16;

    localparam int ADDR_W = 16;
    localparam int BYTE_W = 8;

    localparam logic KIND_POPULATE = 1'b0;
    localparam logic KIND_LOOKUP   = 1'b1;

    typedef struct packed {
        logic                     kind;
        logic [ADDR_W-1:0]        virtual_address;
        logic [ADDR_W-1:0]        phys_addr;
        logic signed [BYTE_W-1:0] write_value;
    } t_in_item;

    typedef struct packed {
        logic signed [BYTE_W-1:0] read_value;
        logic [BYTE_W-1:0]        xlat_frame;
        logic                     tlb_hit;
    } t_out_item;

    // sequencer -> TLB
    typedef struct packed {
        logic start;   // restart the scan at entry 0
        logic step;    // compare current entry, advance on no match
        logic insert;  // write page/frame at the FIFO head
    } t_tlb_ctl;

    // TLB -> sequencer
    typedef struct packed {
        logic match;   // current entry is valid and holds the page
        logic last;    // current entry is the last one
    } t_tlb_sts;

    // sequencer -> memories
    typedef struct packed {
        logic pm_wr;   // page table write
        logic fs_wr;   // physical memory write
    } t_mem_ctl;

endpackage

@@ design/tfpt_tlb.sv @@
// TLB entry array with FIFO replacement and one shared tag comparator that
// walks the entries under control of the top-level sequencer. Uses tfpt_pkg.
module tfpt_tlb
    import tfpt_pkg::*;
#(
    parameter int PAGE_NUMBER_BITS  = DEF_PAGE_NUMBER_BITS,
    parameter int FRAME_NUMBER_BITS = DEF_FRAME_NUMBER_BITS,
    parameter int TLB_ENTRIES       = DEF_TLB_ENTRIES
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_tlb_ctl                     i_ctl,
    input  logic [PAGE_NUMBER_BITS-1:0]  i_page,
    input  logic [FRAME_NUMBER_BITS-1:0] i_frame,
    output t_tlb_sts                     o_sts,
    output logic [FRAME_NUMBER_BITS-1:0] o_frame
);

    localparam int IDX_W = $clog2(TLB_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TLB_ENTRIES - 1);

    logic [PAGE_NUMBER_BITS-1:0]  r_tags   [TLB_ENTRIES];
    logic [FRAME_NUMBER_BITS-1:0] r_frames [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]       r_valid;
    logic [TLB_ENTRIES-1:0]       n_valid;
    logic [IDX_W-1:0]             r_idx;
    logic [IDX_W-1:0]             n_idx;
    logic [IDX_W-1:0]             r_head;
    logic [IDX_W-1:0]             n_head;
    logic                         w_match;
    logic                         w_last;

    assign w_match = r_valid[r_idx] && (r_tags[r_idx] == i_page);
    assign w_last  = (r_idx == LAST_IDX);

    assign o_sts.match = w_match;
    assign o_sts.last  = w_last;
    assign o_frame     = r_frames[r_idx];

    always_comb begin
        n_idx   = r_idx;
        n_head  = r_head;
        n_valid = r_valid;
        if (i_ctl.start) begin
            n_idx = '0;
        end else if (i_ctl.step && !w_match && !w_last) begin
            n_idx = r_idx + 1'b1;
        end
        if (i_ctl.insert) begin
            n_valid[r_head] = 1'b1;
            n_head = (r_head == LAST_IDX) ? '0 : r_head + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_head  <= '0;
            r_valid <= '0;
        end else begin
            r_idx   <= n_idx;
            r_head  <= n_head;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_tags[r_head]   <= i_page;
            r_frames[r_head] <= i_frame;
        end
    end

    a_insert_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.insert |=> r_valid[$past(r_head)] && (r_tags[$past(r_head)] == $past(i_page)))
        else $error("TLB insert did not land at the FIFO head");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.insert |=> $stable(r_head) && $stable(r_valid))
        else $error("TLB head or valid bits changed without an insert");

endmodule

@@ design/tfpt_mem.sv @@
// Page table (cleared by a sweep after reset) and byte-wide physical memory,
// both with registered reads. Uses tfpt_pkg.
module tfpt_mem
    import tfpt_pkg::*;
#(
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
    parameter int PAGE_NUMBER_BITS  = DEF_PAGE_NUMBER_BITS,
    parameter int FRAME_NUMBER_BITS = DEF_FRAME_NUMBER_BITS
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    input  t_mem_ctl                                 i_ctl,
    input  logic [PAGE_NUMBER_BITS-1:0]              i_pm_waddr,
    input  logic [FRAME_NUMBER_BITS-1:0]             i_pm_wdata,
    input  logic [PAGE_NUMBER_BITS-1:0]              i_pm_raddr,
    output logic [FRAME_NUMBER_BITS-1:0]             o_pm_rdata,
    input  logic [FRAME_NUMBER_BITS+OFFSET_BITS-1:0] i_fs_waddr,
    input  logic [BYTE_W-1:0]                        i_fs_wdata,
    input  logic [FRAME_NUMBER_BITS+OFFSET_BITS-1:0] i_fs_raddr,
    output logic [BYTE_W-1:0]                        o_fs_rdata,
    output logic                                     o_busy
);

    localparam int PAGE_COUNT = 1 << PAGE_NUMBER_BITS;
    localparam int STORE_SIZE = 1 << (FRAME_NUMBER_BITS + OFFSET_BITS);

    logic [FRAME_NUMBER_BITS-1:0] r_page_map  [PAGE_COUNT];
    logic [BYTE_W-1:0]            r_frame_store [STORE_SIZE];
    logic [PAGE_NUMBER_BITS-1:0]  r_clr_idx;
    logic [PAGE_NUMBER_BITS-1:0]  n_clr_idx;
    logic                         r_busy;
    logic                         n_busy;
    logic                         w_pm_we;
    logic [PAGE_NUMBER_BITS-1:0]  w_pm_waddr;
    logic [FRAME_NUMBER_BITS-1:0] w_pm_wdata;
    logic [FRAME_NUMBER_BITS-1:0] r_pm_q;
    logic [BYTE_W-1:0]            r_fs_q;

    assign o_busy     = r_busy;
    assign o_pm_rdata = r_pm_q;
    assign o_fs_rdata = r_fs_q;

    // clearing sweep owns the page table write port until it finishes
    assign w_pm_we    = r_busy || i_ctl.pm_wr;
    assign w_pm_waddr = r_busy ? r_clr_idx : i_pm_waddr;
    assign w_pm_wdata = r_busy ? '0 : i_pm_wdata;

    always_comb begin
        n_clr_idx = r_clr_idx;
        n_busy    = r_busy;
        if (r_busy) begin
            n_clr_idx = r_clr_idx + 1'b1;
            if (&r_clr_idx) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_busy    <= 1'b1;
        end else begin
            r_clr_idx <= n_clr_idx;
            r_busy    <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pm_we) begin
            r_page_map[w_pm_waddr] <= w_pm_wdata;
        end
        r_pm_q <= r_page_map[i_pm_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.fs_wr) begin
            r_frame_store[i_fs_waddr] <= i_fs_wdata;
        end
        r_fs_q <= r_frame_store[i_fs_raddr];
    end

endmodule

@@ design/tlb_fifo_page_translation.sv @@
// Top level: lookup sequencer, output register, TLB and memories.
// Depends on tfpt_pkg, tfpt_tlb and tfpt_mem.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) takes populate and
// lookup items; output channel (o_out_valid / i_out_ready / o_out_data)
// gives one result per lookup. Populates give no result.
// A populate writes page table and physical memory at the transfer, and the
// block is ready again in the next cycle.
// A lookup walks the TLB with one shared tag comparator, one entry a cycle
// from entry 0, stopping at a hit; a miss ends in one page table read and a
// TLB fill at the FIFO head. The result comes from a registered read of
// physical memory. The next item is taken the cycle after the result is
// loaded into the output register.
// After reset the page table is zeroed by a sweep over all 2**PAGE_NUMBER_BITS
// entries (256 by default), during which o_in_ready stays low.
// A stalled receiver holds the result in the output register; a new item may
// still be taken, but its result waits until that register is free.
module tlb_fifo_page_translation
    import tfpt_pkg::*;
#(
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
    parameter int PAGE_NUMBER_BITS  = DEF_PAGE_NUMBER_BITS,
    parameter int FRAME_NUMBER_BITS = DEF_FRAME_NUMBER_BITS,
    parameter int TLB_ENTRIES       = DEF_TLB_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_data
);

    localparam int SA_W = FRAME_NUMBER_BITS + OFFSET_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_WALK = 3'd2;
    localparam logic [2:0] S_READ = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;
    logic                         r_out_valid;
    logic                         n_out_valid;
    t_out_item                    r_out;
    logic [PAGE_NUMBER_BITS-1:0]  r_page;
    logic [OFFSET_BITS-1:0]       r_offset;
    logic [FRAME_NUMBER_BITS-1:0] r_frame;
    logic                         r_hit;

    logic                         w_in_fire;
    logic                         w_load_out;
    logic                         w_busy;
    t_tlb_ctl                     w_tlb_ctl;
    t_tlb_sts                     w_tlb_sts;
    t_mem_ctl                     w_mem_ctl;
    logic [FRAME_NUMBER_BITS-1:0] w_tlb_frame;
    logic [FRAME_NUMBER_BITS-1:0] w_pm_rdata;
    logic [BYTE_W-1:0]            w_fs_rdata;
    logic [31:0]                  w_va_ext;
    logic [31:0]                  w_pa_ext;
    logic [31:0]                  w_frame_ext;
    logic [PAGE_NUMBER_BITS-1:0]  w_in_page;
    logic [OFFSET_BITS-1:0]       w_in_offset;
    logic [FRAME_NUMBER_BITS-1:0] w_in_frame;
    logic [OFFSET_BITS-1:0]       w_in_pa_offset;

    // address split; bits beyond the page/frame width drop out
    assign w_va_ext       = 32'(i_in_data.virtual_address);
    assign w_pa_ext       = 32'(i_in_data.phys_addr);
    assign w_in_page      = PAGE_NUMBER_BITS'(w_va_ext >> OFFSET_BITS);
    assign w_in_offset    = OFFSET_BITS'(w_va_ext);
    assign w_in_frame     = FRAME_NUMBER_BITS'(w_pa_ext >> OFFSET_BITS);
    assign w_in_pa_offset = OFFSET_BITS'(w_pa_ext);
    assign w_frame_ext    = 32'(r_frame);

    assign o_in_ready  = (r_state == S_IDLE) && !w_busy;
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign w_load_out  = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    always_comb begin
        n_state          = r_state;
        w_tlb_ctl        = '0;
        w_mem_ctl        = '0;
        w_mem_ctl.pm_wr  = w_in_fire && (i_in_data.kind == KIND_POPULATE);
        w_mem_ctl.fs_wr  = w_in_fire && (i_in_data.kind == KIND_POPULATE);
        case (r_state)
            S_IDLE: begin
                if (w_in_fire && (i_in_data.kind == KIND_LOOKUP)) begin
                    w_tlb_ctl.start = 1'b1;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                w_tlb_ctl.step = 1'b1;
                if (w_tlb_sts.match) begin
                    n_state = S_READ;
                end else if (w_tlb_sts.last) begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                w_tlb_ctl.insert = 1'b1;
                n_state = S_READ;
            end
            S_READ: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (w_load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_page   <= w_in_page;
            r_offset <= w_in_offset;
        end
        if ((r_state == S_SCAN) && w_tlb_sts.match) begin
            r_frame <= w_tlb_frame;
            r_hit   <= 1'b1;
        end else if (r_state == S_WALK) begin
            r_frame <= w_pm_rdata;
            r_hit   <= 1'b0;
        end
        if (w_load_out) begin
            r_out.read_value <= w_fs_rdata;
            r_out.xlat_frame <= w_frame_ext[BYTE_W-1:0];
            r_out.tlb_hit    <= r_hit;
        end
    end

    tfpt_tlb #(
        .PAGE_NUMBER_BITS  (PAGE_NUMBER_BITS),
        .FRAME_NUMBER_BITS (FRAME_NUMBER_BITS),
        .TLB_ENTRIES       (TLB_ENTRIES)
    ) u_tlb (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_tlb_ctl),
        .i_page  (r_page),
        .i_frame (w_pm_rdata),
        .o_sts   (w_tlb_sts),
        .o_frame (w_tlb_frame)
    );

    tfpt_mem #(
        .OFFSET_BITS       (OFFSET_BITS),
        .PAGE_NUMBER_BITS  (PAGE_NUMBER_BITS),
        .FRAME_NUMBER_BITS (FRAME_NUMBER_BITS)
    ) u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_mem_ctl),
        .i_pm_waddr (w_in_page),
        .i_pm_wdata (w_in_frame),
        .i_pm_raddr (r_page),
        .o_pm_rdata (w_pm_rdata),
        .i_fs_waddr ({w_in_frame, w_in_pa_offset}),
        .i_fs_wdata (i_in_data.write_value),
        .i_fs_raddr (SA_W'({r_frame, r_offset})),
        .o_fs_rdata (w_fs_rdata),
        .o_busy     (w_busy)
    );

    a_populate_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in_data.kind == KIND_POPULATE) && !r_out_valid) |=> !o_out_valid)
        else $error("populate transfer produced a result");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && (i_in_data.kind == KIND_LOOKUP)) |=> !o_in_ready)
        else $error("input taken while a lookup is in flight");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid)) |-> ($past(r_state) == S_DONE))
        else $error("result appeared outside the delivery step");

endmodule

@@ tb/sv/tfpt_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for tlb_fifo_page_translation: snoops both channels, keeps a
// shadow page table, TLB and physical memory, and compares every result.
// Depends on tfpt_pkg.
module tfpt_checker
    import tfpt_pkg::*;
#(
    parameter int OFFSET_BITS       = DEF_OFFSET_BITS,
    parameter int PAGE_NUMBER_BITS  = DEF_PAGE_NUMBER_BITS,
    parameter int FRAME_NUMBER_BITS = DEF_FRAME_NUMBER_BITS,
    parameter int TLB_ENTRIES       = DEF_TLB_ENTRIES
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_ready,
    input  t_in_item  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_ready,
    input  t_out_item i_out_data,
    output int        o_fail_count,
    output int        o_pending,
    output int        o_hits,
    output int        o_misses
);

    localparam int PAGES      = 1 << PAGE_NUMBER_BITS;
    localparam int STORE_SIZE = 1 << (FRAME_NUMBER_BITS + OFFSET_BITS);

    logic [FRAME_NUMBER_BITS-1:0] page_frame [PAGES];
    logic [BYTE_W-1:0]            phys_mem   [STORE_SIZE];
    logic [PAGE_NUMBER_BITS-1:0]  tlb_tag    [TLB_ENTRIES];
    logic [FRAME_NUMBER_BITS-1:0] tlb_frame  [TLB_ENTRIES];
    logic [TLB_ENTRIES-1:0]       tlb_live;
    int unsigned                  fifo_ptr;
    t_out_item                    pending_reads [$];

    // Updates the shadow TLB exactly as a lookup transfer does.
    function automatic t_out_item translate_lookup(input logic [ADDR_W-1:0] vaddr);
        logic [PAGE_NUMBER_BITS-1:0]  page;
        logic [OFFSET_BITS-1:0]       offset;
        logic [FRAME_NUMBER_BITS-1:0] frame;
        logic                         hit;
        t_out_item                    res;
        page   = vaddr[OFFSET_BITS +: PAGE_NUMBER_BITS];
        offset = vaddr[OFFSET_BITS-1:0];
        frame  = '0;
        hit    = 1'b0;
        // lowest matching entry wins
        for (int i = 0; i < TLB_ENTRIES; i++) begin
            if (!hit && tlb_live[i] && tlb_tag[i] == page) begin
                hit   = 1'b1;
                frame = tlb_frame[i];
            end
        end
        if (!hit) begin
            frame               = page_frame[page];
            tlb_tag[fifo_ptr]   = page;
            tlb_frame[fifo_ptr] = frame;
            tlb_live[fifo_ptr]  = 1'b1;
            fifo_ptr            = (fifo_ptr + 1) % TLB_ENTRIES;
        end
        res.read_value = phys_mem[{frame, offset}];
        res.xlat_frame = BYTE_W'(frame);
        res.tlb_hit    = hit;
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        t_out_item                    want;
        logic [FRAME_NUMBER_BITS-1:0] pframe;
        if (!i_rst_n) begin
            for (int p = 0; p < PAGES; p++) begin
                page_frame[p] = '0;
            end
            tlb_live = '0;
            fifo_ptr = 0;
            pending_reads.delete();
            o_fail_count = 0;
            o_hits       = 0;
            o_misses     = 0;
            o_pending <= 0;
        end else begin
            // results first, so a stray one is never matched to a lookup
            // taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (pending_reads.size() == 0) begin
                    $error("result transfer with no lookup outstanding");
                    o_fail_count++;
                end else begin
                    want = pending_reads.pop_front();
                    if (i_out_data.read_value !== want.read_value) begin
                        $error("read_value: expected %0d, got %0d",
                               want.read_value, i_out_data.read_value);
                        o_fail_count++;
                    end
                    if (i_out_data.xlat_frame !== want.xlat_frame) begin
                        $error("xlat_frame: expected 0x%02h, got 0x%02h",
                               want.xlat_frame, i_out_data.xlat_frame);
                        o_fail_count++;
                    end
                    if (i_out_data.tlb_hit !== want.tlb_hit) begin
                        $error("tlb_hit: expected %0b, got %0b",
                               want.tlb_hit, i_out_data.tlb_hit);
                        o_fail_count++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                if (i_in_data.kind == KIND_POPULATE) begin
                    pframe = i_in_data.phys_addr[OFFSET_BITS +: FRAME_NUMBER_BITS];
                    page_frame[i_in_data.virtual_address[OFFSET_BITS +: PAGE_NUMBER_BITS]]
                        = pframe;
                    phys_mem[{pframe, i_in_data.phys_addr[OFFSET_BITS-1:0]}]
                        = i_in_data.write_value;
                end else begin
                    want = translate_lookup(i_in_data.virtual_address);
                    if (want.tlb_hit) begin
                        o_hits++;
                    end else begin
                        o_misses++;
                    end
                    pending_reads.push_back(want);
                end
            end
            o_pending <= pending_reads.size();
        end
    end

endmodule

@@ tb/sv/tb_tlb_fifo_page_translation.sv @@
`timescale 1ns / 1ps
// Testbench top for tlb_fifo_page_translation: clock, reset, populate and
// lookup traffic, random back-pressure and the verdict. Depends on tfpt_pkg,
// the block and tfpt_checker.
module tb_tlb_fifo_page_translation;
    import tfpt_pkg::*;

    localparam int PAGES      = 1 << DEF_PAGE_NUMBER_BITS;
    localparam int FRAMES     = 1 << DEF_FRAME_NUMBER_BITS;
    localparam int STORE_SIZE = 1 << (DEF_FRAME_NUMBER_BITS + DEF_OFFSET_BITS);
    localparam int STALL_LIMIT = 2000;
    localparam int PHASES      = 16;
    localparam int PHASE_ITEMS = 59;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_ready;
    t_in_item  i_in_data;
    logic      o_out_valid;
    logic      i_out_ready;
    t_out_item o_out_data;

    int fail_count;
    int pending;
    int hits;
    int misses;
    int n_populate;
    int n_lookup;
    int idle_cycles;
    bit no_idle;

    // Every frame a page was ever mapped to; a stale TLB entry can only
    // return one of these. Used to keep lookups off unwritten bytes.
    bit [FRAMES-1:0] page_history [PAGES];
    bit              mem_written  [STORE_SIZE];

    bit [7:0] page_pool  [24];
    bit [7:0] frame_pool [16];
    bit [7:0] offs_pool  [8] = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h33, 8'hCC};

    tlb_fifo_page_translation u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    tfpt_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .i_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_out_data  (o_out_data),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_hits      (hits),
        .o_misses    (misses)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int draw_gap();
        if (no_idle) begin
            return 0;
        end
        return $urandom_range(0, 9);
    endfunction

    function automatic bit lookup_safe(input bit [7:0] page, input bit [7:0] offset);
        for (int f = 0; f < FRAMES; f++) begin
            if (page_history[page][f] && !mem_written[{f[7:0], offset}]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // Returns at the edge where the transfer happened.
    task automatic send_item(input t_in_item item);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (!o_in_ready);
        if (item.kind == KIND_POPULATE) begin
            page_history[item.virtual_address[15:8]][item.phys_addr[15:8]] = 1'b1;
            mem_written[item.phys_addr] = 1'b1;
            n_populate++;
        end else begin
            n_lookup++;
        end
    endtask

    task automatic populate(input bit [7:0] page, input bit [7:0] frame,
                            input bit [7:0] offset, input bit [7:0] value);
        t_in_item item;
        item.kind            = KIND_POPULATE;
        item.virtual_address = {page, 8'($urandom)};
        item.phys_addr       = {frame, offset};
        item.write_value     = value;
        send_item(item);
    endtask

    task automatic lookup(input bit [7:0] page, input bit [7:0] offset);
        t_in_item item;
        item.kind            = KIND_LOOKUP;
        item.virtual_address = {page, offset};
        item.phys_addr       = 16'($urandom);
        item.write_value     = 8'($urandom);
        send_item(item);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    function automatic bit [7:0] pick(input bit [7:0] pooled, input int pool_pct);
        if ($urandom_range(0, 99) < pool_pct) begin
            return pooled;
        end
        return 8'($urandom);
    endfunction

    // Mostly pooled pages, frames and offsets so lookups land on written bytes,
    // evictions happen and remapped pages leave stale TLB entries behind.
    task automatic random_item();
        bit [7:0] page;
        bit [7:0] offset;
        bit       sent;
        sent = 1'b0;
        if ($urandom_range(0, 99) >= 25) begin
            for (int t = 0; t < 8 && !sent; t++) begin
                page   = pick(page_pool[$urandom_range(0, 23)], 85);
                offset = pick(offs_pool[$urandom_range(0, 7)], 85);
                if (lookup_safe(page, offset)) begin
                    lookup(page, offset);
                    sent = 1'b1;
                end
            end
        end
        if (!sent) begin
            populate(pick(page_pool[$urandom_range(0, 23)], 90),
                     pick(frame_pool[$urandom_range(0, 15)], 90),
                     pick(offs_pool[$urandom_range(0, 7)], 80),
                     8'($urandom));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // Result side: random stall before each result.
    initial begin : result_sink
        int gap;
        i_out_ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_data   <= '0;
        n_populate   = 0;
        n_lookup     = 0;
        no_idle      = 1'b0;
        for (int p = 0; p < PAGES; p++) begin
            page_history[p] = FRAMES'(1);   // unmapped pages read frame zero
        end
        page_pool[0]  = 8'h00;
        page_pool[1]  = 8'hFF;
        page_pool[2]  = 8'h10;
        for (int i = 3; i < 24; i++) begin
            page_pool[i] = 8'($urandom);
        end
        frame_pool[0] = 8'h00;
        frame_pool[1] = 8'hFF;
        for (int i = 2; i < 16; i++) begin
            frame_pool[i] = 8'($urandom);
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, unmapped page, hit after miss, stale hit
        populate(8'h10, 8'h00, 8'h00, 8'h80);
        populate(8'h10, 8'h00, 8'hFF, 8'h7F);
        lookup(8'h00, 8'h00);
        lookup(8'h00, 8'hFF);
        populate(8'hFF, 8'hFF, 8'hFF, 8'h5A);
        populate(8'hFF, 8'hFF, 8'h00, 8'hFF);
        lookup(8'hFF, 8'hFF);
        lookup(8'hFF, 8'h00);
        lookup(8'h10, 8'h00);
        populate(8'hFF, 8'h3C, 8'h00, 8'h01);
        lookup(8'hFF, 8'h00);
        populate(8'hAA, 8'h00, 8'hAA, 8'hA5);
        populate(8'h55, 8'hAA, 8'hAA, 8'h3C);
        lookup(8'h55, 8'hAA);
        lookup(8'hAA, 8'hAA);
        drain_results();

        for (int ph = 0; ph < PHASES; ph++) begin
            no_idle = (ph % 4 == 1);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                random_item();
            end
            if (ph % 5 == 4) begin
                drain_results();
            end
        end

        drain_results();
        repeat (DEF_TLB_ENTRIES + 8) @(posedge i_clk);
        $display("Sent %0d populates and %0d lookups; results saw %0d TLB hits, %0d misses.",
                 n_populate, n_lookup, hits, misses);
        $display("Mismatches or stray results: %0d", fail_count);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
